// ----- rtl/hlsa_pkg.sv -----
`timescale 1ns / 1ps

package hlsa_pkg;

	// hue angles in q16 degrees
	localparam logic [24:0] DEG60  = 25'd3932160;
	localparam logic [24:0] DEG120 = 25'd7864320;
	localparam logic [24:0] DEG180 = 25'd11796480;
	localparam logic [24:0] DEG240 = 25'd15728640;
	localparam logic [24:0] DEG360 = 25'd23592960;

	localparam logic [1:0] CFG_LIGHT = 2'd0;
	localparam logic [1:0] CFG_SAT   = 2'd1;

	typedef enum logic [1:0] {
		SEG_RISE,
		SEG_HIGH,
		SEG_FALL,
		SEG_LOW
	} seg_t;

	typedef struct packed {
		logic [7:0]  l;
		logic [18:0] sat_rem;
		logic [10:0] sat_den;
		logic [7:0]  sat_q;
		logic [18:0] hue_rem;
		logic [10:0] hue_den;
		logic [7:0]  hue_q;
	} div_t;

	typedef struct packed {
		logic [7:0] l;
		logic [7:0] s;
		logic [7:0] h;
	} hls_t;

	typedef struct packed {
		logic        grey;
		logic [7:0]  l;
		logic [16:0] hi;
		logic [16:0] lo;
		logic [24:0] hue;
	} rng_t;

endpackage

// ----- rtl/hlsa_fwd.sv -----
`timescale 1ns / 1ps

module hlsa_fwd (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  logic [7:0]    r,
	input  logic [7:0]    g,
	input  logic [7:0]    b,
	output logic          v_out,
	output hlsa_pkg::div_t d_out
);
	import hlsa_pkg::*;

	logic [7:0]  mx, mn, d;
	logic [8:0]  sm;
	logic [11:0] d6, n;
	div_t        nxt, d_s1;
	logic        v_s1;

	always_comb begin
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d  = mx - mn;
		sm = {1'b0, mx} + {1'b0, mn};
		d6 = {2'b0, d, 2'b0} + {3'b0, d, 1'b0};
		if (b == mx) begin
			n = {2'b0, d, 2'b0} + {4'b0, r} - {4'b0, g};
		end else if (g == mx) begin
			n = {3'b0, d, 1'b0} + {4'b0, b} - {4'b0, r};
		end else if (g > b) begin
			n = {4'b0, g} - {4'b0, b};
		end else begin
			n = d6 + {4'b0, g} - {4'b0, b};
		end
		nxt.l     = sm[8:1];
		nxt.sat_q = '0;
		nxt.hue_q = '0;
		if (d == 8'd0) begin
			// grey: zero numerators give zero quotients
			nxt.sat_rem = '0;
			nxt.sat_den = 11'd1;
			nxt.hue_rem = '0;
			nxt.hue_den = 11'd1;
		end else begin
			nxt.sat_rem = {3'b0, d, 8'b0} - {11'b0, d};
			nxt.sat_den = (sm <= 9'd255) ? {2'b0, sm} : {2'b0, 9'd510 - sm};
			nxt.hue_rem = {n[10:0], 8'b0} - {8'b0, n[10:0]};
			nxt.hue_den = d6[10:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= nxt;
		end
	end

	assign v_out = v_s1;
	assign d_out = d_s1;

endmodule

// ----- rtl/hlsa_div.sv -----
`timescale 1ns / 1ps

module hlsa_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           v_in,
	input  hlsa_pkg::div_t d_in,
	output logic           v_out,
	output hlsa_pkg::hls_t q_out
);
	import hlsa_pkg::*;

	div_t st_s  [8];
	logic vld_s [8];

	// one quotient bit per stage, both lanes in step
	for (genvar k = 0; k < 8; k++) begin : g_step
		localparam int SH = 7 - k;
		div_t        src, nxt;
		logic        vsrc;
		logic [18:0] sd, hd;

		if (k == 0) begin : g_first
			assign src  = d_in;
			assign vsrc = v_in;
		end else begin : g_next
			assign src  = st_s[k-1];
			assign vsrc = vld_s[k-1];
		end

		assign sd = {8'b0, src.sat_den} << SH;
		assign hd = {8'b0, src.hue_den} << SH;

		always_comb begin
			nxt = src;
			if (src.sat_rem >= sd) begin
				nxt.sat_rem   = src.sat_rem - sd;
				nxt.sat_q[SH] = 1'b1;
			end
			if (src.hue_rem >= hd) begin
				nxt.hue_rem   = src.hue_rem - hd;
				nxt.hue_q[SH] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vsrc;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k] <= nxt;
			end
		end
	end

	assign v_out   = vld_s[7];
	assign q_out.l = st_s[7].l;
	assign q_out.s = st_s[7].sat_q;
	assign q_out.h = st_s[7].hue_q;

endmodule

// ----- rtl/hlsa_adj.sv -----
`timescale 1ns / 1ps

module hlsa_adj (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           v_in,
	input  hlsa_pkg::hls_t d_in,
	input  logic [7:0]     light_pct,
	input  logic [7:0]     sat_pct,
	output logic           v_out,
	output hlsa_pkg::hls_t d_out
);
	import hlsa_pkg::*;

	function automatic logic signed [7:0] clamp(input logic [7:0] raw);
		logic signed [7:0] x;
		x = $signed(raw);
		if (x > 8'sd100) x = 8'sd100;
		if (x < -8'sd100) x = -8'sd100;
		return x;
	endfunction

	function automatic logic [14:0] scale(input logic [7:0] v, input logic signed [7:0] p);
		logic [6:0]        m;
		logic [7:0]        av;
		logic signed [7:0] sum;
		sum = 8'sd100 + p;
		m   = '0;
		av  = v;
		if (p > 8'sd0) begin
			m  = p[6:0];
			av = 8'd255 - v;
		end else if (p < 8'sd0) begin
			m = sum[6:0];
		end
		return {7'b0, av} * {8'b0, m};
	endfunction

	function automatic logic [7:0] div100(input logic [14:0] x);
		logic [27:0] pr;
		pr = {13'b0, x} * 28'd5243;
		return pr[26:19];
	endfunction

	logic signed [7:0] pl, ps;
	logic [14:0]       xl_s1, xs_s1;
	logic [7:0]        l_s1, s_s1, h_s1;
	logic              lpos_s1, lneg_s1, spos_s1, sneg_s1;
	logic              v_s1, v_s2;
	logic [7:0]        ql, qs;
	hls_t              res, d_s2;

	assign pl = clamp(light_pct);
	assign ps = clamp(sat_pct);

	always_ff @(posedge clk) begin
		if (en) begin
			xl_s1   <= scale(d_in.l, pl);
			xs_s1   <= scale(d_in.s, ps);
			l_s1    <= d_in.l;
			s_s1    <= d_in.s;
			h_s1    <= d_in.h;
			lpos_s1 <= pl > 8'sd0;
			lneg_s1 <= pl < 8'sd0;
			spos_s1 <= ps > 8'sd0;
			sneg_s1 <= ps < 8'sd0;
		end
	end

	always_comb begin
		ql    = div100(xl_s1);
		qs    = div100(xs_s1);
		res.h = h_s1;
		res.l = lpos_s1 ? l_s1 + ql : (lneg_s1 ? ql : l_s1);
		res.s = spos_s1 ? s_s1 + qs : (sneg_s1 ? qs : s_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	assign v_out = v_s2;
	assign d_out = d_s2;

endmodule

// ----- rtl/hlsa_back.sv -----
`timescale 1ns / 1ps

module hlsa_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           v_in,
	input  hlsa_pkg::hls_t d_in,
	output logic           v_out,
	output hlsa_pkg::rng_t d_out
);
	import hlsa_pkg::*;

	// x * 65536 / 65025, exact for x up to 65025
	function automatic logic [16:0] to_q16(input logic [15:0] x);
		logic [41:0] pr;
		pr = {26'b0, x} * 42'd33752070;
		return {1'b0, x} + {7'b0, pr[41:32]};
	endfunction

	logic [15:0] ls, l255, s255;
	logic [16:0] hin, lon, l510;
	logic [15:0] hin_s1, lon_s1;
	logic [24:0] hm_s1;
	logic [10:0] h7_s1;
	logic [7:0]  l_s1;
	logic        grey_s1, v_s1, v_s2;
	logic [22:0] hf;
	rng_t        d_s2;

	always_comb begin
		ls   = {8'b0, d_in.l} * {8'b0, d_in.s};
		l255 = {d_in.l, 8'b0} - {8'b0, d_in.l};
		s255 = {d_in.s, 8'b0} - {8'b0, d_in.s};
		l510 = {d_in.l, 9'b0} - {8'b0, d_in.l, 1'b0};
		if (d_in.l <= 8'd127) begin
			hin = {1'b0, l255} + {1'b0, ls};
		end else begin
			hin = {1'b0, l255} + {1'b0, s255} - {1'b0, ls};
		end
		lon = l510 - hin;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hin_s1  <= hin[15:0];
			lon_s1  <= lon[15:0];
			hm_s1   <= {17'b0, d_in.h} * 25'd92521;
			h7_s1   <= {d_in.h, 3'b0} - {3'b0, d_in.h};
			l_s1    <= d_in.l;
			grey_s1 <= d_in.s == 8'd0;
		end
	end

	assign hf = {12'b0, h7_s1} * 23'd3856;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2.grey <= grey_s1;
			d_s2.l    <= l_s1;
			d_s2.hi   <= to_q16(hin_s1);
			d_s2.lo   <= to_q16(lon_s1);
			d_s2.hue  <= hm_s1 + {18'b0, hf[22:16]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	assign v_out = v_s2;
	assign d_out = d_s2;

endmodule

// ----- rtl/hlsa_chan.sv -----
`timescale 1ns / 1ps

module hlsa_chan (
	input  logic               clk,
	input  logic               en,
	input  logic [16:0]        hi,
	input  logic [16:0]        lo,
	input  logic signed [25:0] ang,
	output logic [7:0]         val
);
	import hlsa_pkg::*;

	logic signed [25:0] aw;
	logic [24:0]        au;
	logic [21:0]        t;
	seg_t               seg;
	logic [21:0]        t_s1;
	seg_t               seg_s1, seg_s2;
	logic [16:0]        hi_s1, lo_s1, hi_s2, lo_s2, v_s3;
	logic [16:0]        diff;
	logic [38:0]        prod;
	logic [19:0]        z_s2;
	logic [40:0]        qp;
	logic [16:0]        v;
	logic [24:0]        ov;
	logic [7:0]         val_s4;

	always_comb begin
		aw = ang;
		if (ang > $signed({1'b0, DEG360})) begin
			aw = ang - $signed({1'b0, DEG360});
		end else if (ang < 26'sd0) begin
			aw = ang + $signed({1'b0, DEG360});
		end
		au = aw[24:0];
		t  = '0;
		if (au < DEG60) begin
			seg = SEG_RISE;
			t   = au[21:0];
		end else if (au < DEG180) begin
			seg = SEG_HIGH;
		end else if (au < DEG240) begin
			seg = SEG_FALL;
			t   = 22'(DEG240 - au);
		end else begin
			seg = SEG_LOW;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= t;
			seg_s1 <= seg;
			hi_s1  <= hi;
			lo_s1  <= lo;
		end
	end

	assign diff = hi_s1 - lo_s1;
	assign prod = {22'b0, diff} * {17'b0, t_s1};

	always_ff @(posedge clk) begin
		if (en) begin
			z_s2   <= prod[37:18];
			seg_s2 <= seg_s1;
			hi_s2  <= hi_s1;
			lo_s2  <= lo_s1;
		end
	end

	// divide by 15 through a reciprocal
	assign qp = {21'b0, z_s2} * 41'd1118482;

	always_comb begin
		case (seg_s2)
			SEG_RISE, SEG_FALL: v = lo_s2 + {1'b0, qp[39:24]};
			SEG_HIGH:           v = hi_s2;
			default:            v = lo_s2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s3 <= v;
		end
	end

	assign ov = {8'b0, v_s3} * 25'd255;

	always_ff @(posedge clk) begin
		if (en) begin
			val_s4 <= ov[23:16];
		end
	end

	assign val = val_s4;

endmodule

// ----- rtl/hls_lightness_saturation_adjust.sv -----
`timescale 1ns / 1ps

// Adjusts lightness and saturation of an RGB pixel stream in HLS space. One pixel
// is taken every clock while the output is not stalled; the depth is set by the
// forward stage, eight one-bit stages of the saturation and hue dividers, the
// adjust and back-conversion stages and four-stage per-channel interpolator. The
// whole pipeline advances together and holds while the output beat is not taken.
// Registers 0 (lightness) and 1 (saturation) are signed percentages, clamped to
// -100..100; write them only while no pixel is in flight.

module hls_lightness_saturation_adjust (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // red_out, green_out, blue_out
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import hlsa_pkg::*;

	logic               en;
	logic [7:0]         light_q, sat_q;
	logic               v_fwd, v_div, v_adj, v_back;
	div_t               d_fwd;
	hls_t               d_div, d_adj;
	rng_t               d_back;
	logic signed [25:0] hue_sg, a_red, a_blue;
	logic [7:0]         r_ch, g_ch, b_ch;
	logic               vc_s1, vc_s2, vc_s3, vc_s4;
	logic               grey_s1, grey_s2, grey_s3, grey_s4;
	logic [7:0]         l_s1, l_s2, l_s3, l_s4;

	assign en       = !vc_s4 || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q <= '0;
			sat_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LIGHT: light_q <= cfg_data;
				CFG_SAT:   sat_q   <= cfg_data;
				default:   ;
			endcase
		end
	end

	hlsa_fwd u_fwd (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (s_tvalid),
		.r      (s_tdata[7:0]),
		.g      (s_tdata[15:8]),
		.b      (s_tdata[23:16]),
		.v_out  (v_fwd),
		.d_out  (d_fwd)
	);

	hlsa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_fwd),
		.d_in   (d_fwd),
		.v_out  (v_div),
		.q_out  (d_div)
	);

	hlsa_adj u_adj (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.v_in      (v_div),
		.d_in      (d_div),
		.light_pct (light_q),
		.sat_pct   (sat_q),
		.v_out     (v_adj),
		.d_out     (d_adj)
	);

	hlsa_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_adj),
		.d_in   (d_adj),
		.v_out  (v_back),
		.d_out  (d_back)
	);

	assign hue_sg = $signed({1'b0, d_back.hue});
	assign a_red  = hue_sg + $signed({1'b0, DEG120});
	assign a_blue = hue_sg - $signed({1'b0, DEG120});

	hlsa_chan u_red (
		.clk (clk),
		.en  (en),
		.hi  (d_back.hi),
		.lo  (d_back.lo),
		.ang (a_red),
		.val (r_ch)
	);

	hlsa_chan u_green (
		.clk (clk),
		.en  (en),
		.hi  (d_back.hi),
		.lo  (d_back.lo),
		.ang (hue_sg),
		.val (g_ch)
	);

	hlsa_chan u_blue (
		.clk (clk),
		.en  (en),
		.hi  (d_back.hi),
		.lo  (d_back.lo),
		.ang (a_blue),
		.val (b_ch)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_s1 <= 1'b0;
			vc_s2 <= 1'b0;
			vc_s3 <= 1'b0;
			vc_s4 <= 1'b0;
		end else if (en) begin
			vc_s1 <= v_back;
			vc_s2 <= vc_s1;
			vc_s3 <= vc_s2;
			vc_s4 <= vc_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grey_s1 <= d_back.grey;
			grey_s2 <= grey_s1;
			grey_s3 <= grey_s2;
			grey_s4 <= grey_s3;
			l_s1    <= d_back.l;
			l_s2    <= l_s1;
			l_s3    <= l_s2;
			l_s4    <= l_s3;
		end
	end

	assign m_tvalid = vc_s4;
	assign m_tdata  = grey_s4 ? {l_s4, l_s4, l_s4} : {b_ch, g_ch, r_ch};

endmodule
